/* hdl/b2da_pkg.sv */
// ---------------------------------------------------------------------------
// b2da_pkg
// shared widths, constants and controller/datapath types for the
// binary to decimal ascii unit
// ---------------------------------------------------------------------------
package b2da_pkg;

    localparam int VALUE_WIDTH = 32;
    // floor(w * log10(2)) + 1 decimal digits cover any w-bit value
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int CHAR_W      = 6;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int ASCII_ZERO  = 48;

    typedef struct packed {
        logic load;         // take a new value, clear the digits
        logic conv_step;    // one double dabble step
        logic digit_shift;  // drop the top digit
    } b2da_cmd_t;

    typedef struct packed {
        logic top_zero;     // most significant digit is zero
    } b2da_status_t;

endpackage

/* hdl/b2da_value_if.sv */
// ---------------------------------------------------------------------------
// b2da_value_if
// request channel carrying one binary value
// ---------------------------------------------------------------------------
interface b2da_value_if
    import b2da_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* hdl/b2da_digit_if.sv */
// ---------------------------------------------------------------------------
// b2da_digit_if
// result channel carrying one ascii digit and its end-of-run flag
// ---------------------------------------------------------------------------
interface b2da_digit_if
    import b2da_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

/* hdl/b2da_dp.sv */
// ---------------------------------------------------------------------------
// b2da_dp
// datapath: binary shift register, bcd digit register with add-3 correction
// ---------------------------------------------------------------------------
module b2da_dp
    import b2da_pkg::*;
(
    input  logic                   clk,
    input  b2da_cmd_t              cmd,
    input  logic [VALUE_WIDTH-1:0] value,
    output b2da_status_t           status,
    output logic [CHAR_W-1:0]      digit_char
);

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (cmd.load)
        begin
            bin_next = value;
            bcd_next = '0;
        end
        else if (cmd.conv_step)
        begin
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
        end
        else if (cmd.digit_shift)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit       = bcd_reg[BCD_W-1 -: 4];
    assign status.top_zero = (top_digit == 4'd0);
    assign digit_char      = CHAR_W'(ASCII_ZERO) | CHAR_W'(top_digit);

endmodule

/* hdl/b2da_ctrl.sv */
// ---------------------------------------------------------------------------
// b2da_ctrl
// controller: sequences load, conversion, leading-zero skip and digit output
// ---------------------------------------------------------------------------
module b2da_ctrl
    import b2da_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         out_last,
    input  b2da_status_t status,
    output b2da_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic [DIG_CNT_W-1:0] dig_cnt_reg;
    logic [DIG_CNT_W-1:0] dig_cnt_next;
    logic                 one_left;

    assign one_left  = (dig_cnt_reg == DIG_CNT_W'(1));
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_last  = one_left;

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                bit_cnt_next  = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1))
                begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros but always keep the units digit
                if (status.top_zero && !one_left)
                begin
                    cmd.digit_shift = 1'b1;
                    dig_cnt_next    = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (one_left)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.digit_shift = 1'b1;
                        dig_cnt_next    = dig_cnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

endmodule

/* hdl/binary_to_decimal_ascii_unit.sv */
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// converts an unsigned 32-bit value into ascii decimal digits, msd first
// ---------------------------------------------------------------------------
// usage:
//   number : valid/ready request channel carrying one 32-bit value
//   text   : valid/ready channel, one ascii digit per transfer; last_digit
//            marks the units digit that ends the run. leading zeros are
//            dropped, zero gives the single digit '0'.
// operation:
//   a request is taken only while the unit is idle. conversion is a
//   shift-and-add-3 loop over the 32 value bits, one bit per cycle, then
//   up to 9 leading zero digits are skipped one per cycle. digits then
//   go out one per cycle while text.ready is high; conversion and the
//   zero skip do not wait on it. the next request is taken only once the
//   unit is back in idle after the units digit has been accepted.
// stall: in output, a low text.ready holds the current digit and nothing
//   advances. reset returns the unit to idle, discarding any run in flight.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii_unit
    import b2da_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    b2da_value_if.sink   number,
    b2da_digit_if.source text
);

    b2da_cmd_t    cmd;
    b2da_status_t status;

    b2da_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (number.valid),
        .in_ready  (number.ready),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .out_last  (text.last_digit),
        .status    (status),
        .cmd       (cmd)
    );

    b2da_dp u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .value      (number.value),
        .status     (status),
        .digit_char (text.digit_char)
    );

endmodule
